// ===== src/qrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion rotate/compose package
// Fixed-point widths, request and result types, control word encoding and the
// microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package qrc_pkg;

  // Quaternion parts are Q2.14, vectors Q12.12.
  localparam int QUAT_WIDTH  = 16;
  localparam int VEC_WIDTH   = 24;
  localparam int QUAT_FRAC   = QUAT_WIDTH - 2;
  // One cross product part after its floor shift.
  localparam int CROSS_WIDTH = QUAT_WIDTH + VEC_WIDTH + 1 - QUAT_FRAC;
  localparam int PROD_WIDTH  = QUAT_WIDTH + CROSS_WIDTH;
  localparam int ACC_WIDTH   = PROD_WIDTH + 2;
  // Rotated vector before saturation: v + t + d.
  localparam int ROT_WIDTH   = ACC_WIDTH - QUAT_FRAC + 2;

  localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1) << QUAT_FRAC;

  // Operation codes.
  localparam logic [1:0] OP_ROTATE  = 2'd0;
  localparam logic [1:0] OP_COMPOSE = 2'd1;
  localparam logic [1:0] OP_LOAD    = 2'd2;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [QUAT_WIDTH-1:0] quat_w;
  } req_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0]  rot_x;
    logic signed [VEC_WIDTH-1:0]  rot_y;
    logic signed [VEC_WIDTH-1:0]  rot_z;
    logic signed [QUAT_WIDTH-1:0] cur_x;
    logic signed [QUAT_WIDTH-1:0] cur_y;
    logic signed [QUAT_WIDTH-1:0] cur_z;
    logic signed [QUAT_WIDTH-1:0] cur_w;
  } rsp_t;

  // Control word fields.
  typedef enum logic [1:0] {SA_X, SA_Y, SA_Z, SA_W} sel_a_e;

  typedef enum logic [3:0] {
    SB_V0, SB_V1, SB_V2, SB_C0, SB_C1, SB_C2, SB_Q0, SB_Q1, SB_Q2, SB_Q3
  } sel_b_e;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_e;

  typedef enum logic [2:0] {
    WB_NONE,      // no write
    WB_CROSS,     // cross part c[i] = acc >>> QUAT_FRAC
    WB_RINIT,     // r[i] = v[i] + (acc >>> QUAT_FRAC-1)
    WB_RADD,      // r[i] += acc >>> QUAT_FRAC-1
    WB_NEW,       // new quaternion part n[i] = sat(acc >>> QUAT_FRAC)
    WB_COMMIT_N,  // held quaternion takes n
    WB_COMMIT_Q   // held quaternion takes the request's quaternion
  } wb_e;

  typedef enum logic [1:0] {SEQ_NEXT, SEQ_DISPATCH, SEQ_END} seq_e;

  typedef struct packed {
    sel_a_e     mul_a;
    sel_b_e     mul_b;
    acc_e       acc;
    wb_e        wb;
    logic [1:0] wb_idx;
    seq_e       seq;
  } ctrl_t;

  // Sequencer handshake with the top level.
  typedef struct packed {
    logic       start;
    logic       out_free;
    logic [1:0] op;
  } seq_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_status_t;

  localparam ctrl_t CTRL_IDLE = '{
    mul_a: SA_X, mul_b: SB_V0, acc: ACC_HOLD, wb: WB_NONE, wb_idx: 2'd0, seq: SEQ_END
  };

  // Microprogram layout.
  localparam int PC_W          = 6;
  localparam int DISPATCH_ADDR = 0;
  localparam int ROT_BASE      = 1;   // 18 words
  localparam int CMP_BASE      = 19;  // 20 words
  localparam int LOAD_BASE     = 39;  // 2 words
  localparam int NOP_BASE      = 41;  // 1 word
  localparam int LAST_ADDR     = 41;

  function automatic ctrl_t mk(input sel_a_e a, input sel_b_e b, input acc_e ac,
                               input wb_e wb, input logic [1:0] idx, input seq_e sq);
    ctrl_t w;
    w.mul_a  = a;
    w.mul_b  = b;
    w.acc    = ac;
    w.wb     = wb;
    w.wb_idx = idx;
    w.seq    = sq;
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry(input logic [1:0] op);
    logic [PC_W-1:0] a;
    case (op)
      OP_ROTATE:  a = PC_W'(ROT_BASE);
      OP_COMPOSE: a = PC_W'(CMP_BASE);
      OP_LOAD:    a = PC_W'(LOAD_BASE);
      default:    a = PC_W'(NOP_BASE);
    endcase
    return a;
  endfunction

  // Each word multiplies a*b into the product register, folds the previous
  // product into the accumulator and writes back from the accumulator as it
  // stood at the start of the step.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_W'(DISPATCH_ADDR): w = mk(SA_X, SB_V0, ACC_HOLD, WB_NONE, 2'd0, SEQ_DISPATCH);
      // Rotation: c = u x v, t = 2 w c, d = 2 u x c, r = v + t + d.
      PC_W'(ROT_BASE + 0):  w = mk(SA_Y, SB_V2, ACC_HOLD, WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 1):  w = mk(SA_Z, SB_V1, ACC_LOAD, WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 2):  w = mk(SA_Z, SB_V0, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 3):  w = mk(SA_X, SB_V2, ACC_LOAD, WB_CROSS, 2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 4):  w = mk(SA_X, SB_V1, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 5):  w = mk(SA_Y, SB_V0, ACC_LOAD, WB_CROSS, 2'd1, SEQ_NEXT);
      PC_W'(ROT_BASE + 6):  w = mk(SA_W, SB_C0, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 7):  w = mk(SA_W, SB_C1, ACC_LOAD, WB_CROSS, 2'd2, SEQ_NEXT);
      PC_W'(ROT_BASE + 8):  w = mk(SA_W, SB_C2, ACC_LOAD, WB_RINIT, 2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 9):  w = mk(SA_Y, SB_C2, ACC_LOAD, WB_RINIT, 2'd1, SEQ_NEXT);
      PC_W'(ROT_BASE + 10): w = mk(SA_Z, SB_C1, ACC_LOAD, WB_RINIT, 2'd2, SEQ_NEXT);
      PC_W'(ROT_BASE + 11): w = mk(SA_Z, SB_C0, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 12): w = mk(SA_X, SB_C2, ACC_LOAD, WB_RADD,  2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 13): w = mk(SA_X, SB_C1, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 14): w = mk(SA_Y, SB_C0, ACC_LOAD, WB_RADD,  2'd1, SEQ_NEXT);
      PC_W'(ROT_BASE + 15): w = mk(SA_X, SB_V0, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(ROT_BASE + 16): w = mk(SA_X, SB_V0, ACC_HOLD, WB_RADD,  2'd2, SEQ_NEXT);
      PC_W'(ROT_BASE + 17): w = mk(SA_X, SB_V0, ACC_HOLD, WB_NONE,  2'd0, SEQ_END);
      // Hamilton product held * request, four sums of four products.
      PC_W'(CMP_BASE + 0):  w = mk(SA_W, SB_Q0, ACC_HOLD, WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 1):  w = mk(SA_X, SB_Q3, ACC_LOAD, WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 2):  w = mk(SA_Y, SB_Q2, ACC_ADD,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 3):  w = mk(SA_Z, SB_Q1, ACC_ADD,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 4):  w = mk(SA_W, SB_Q1, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 5):  w = mk(SA_X, SB_Q2, ACC_LOAD, WB_NEW,   2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 6):  w = mk(SA_Y, SB_Q3, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 7):  w = mk(SA_Z, SB_Q0, ACC_ADD,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 8):  w = mk(SA_W, SB_Q2, ACC_ADD,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 9):  w = mk(SA_X, SB_Q1, ACC_LOAD, WB_NEW,   2'd1, SEQ_NEXT);
      PC_W'(CMP_BASE + 10): w = mk(SA_Y, SB_Q0, ACC_ADD,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 11): w = mk(SA_Z, SB_Q3, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 12): w = mk(SA_W, SB_Q3, ACC_ADD,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 13): w = mk(SA_X, SB_Q0, ACC_LOAD, WB_NEW,   2'd2, SEQ_NEXT);
      PC_W'(CMP_BASE + 14): w = mk(SA_Y, SB_Q1, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 15): w = mk(SA_Z, SB_Q2, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 16): w = mk(SA_X, SB_V0, ACC_SUB,  WB_NONE,  2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 17): w = mk(SA_X, SB_V0, ACC_HOLD, WB_NEW,   2'd3, SEQ_NEXT);
      PC_W'(CMP_BASE + 18): w = mk(SA_X, SB_V0, ACC_HOLD, WB_COMMIT_N, 2'd0, SEQ_NEXT);
      PC_W'(CMP_BASE + 19): w = mk(SA_X, SB_V0, ACC_HOLD, WB_NONE,  2'd0, SEQ_END);
      // Load, then the no-op.
      PC_W'(LOAD_BASE + 0): w = mk(SA_X, SB_V0, ACC_HOLD, WB_COMMIT_Q, 2'd0, SEQ_NEXT);
      PC_W'(LOAD_BASE + 1): w = mk(SA_X, SB_V0, ACC_HOLD, WB_NONE,  2'd0, SEQ_END);
      PC_W'(NOP_BASE):      w = mk(SA_X, SB_V0, ACC_HOLD, WB_NONE,  2'd0, SEQ_END);
      default:              w = CTRL_IDLE;
    endcase
    return w;
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] sat_vec(
      input logic signed [ROT_WIDTH-1:0] x);
    logic signed [ROT_WIDTH-1:0] hi;
    logic signed [ROT_WIDTH-1:0] lo;
    hi = {{(ROT_WIDTH-VEC_WIDTH+1){1'b0}}, {(VEC_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      return {1'b0, {(VEC_WIDTH-1){1'b1}}};
    end else if (x < lo) begin
      return {1'b1, {(VEC_WIDTH-1){1'b0}}};
    end
    return x[VEC_WIDTH-1:0];
  endfunction

  function automatic logic signed [QUAT_WIDTH-1:0] sat_quat(
      input logic signed [ACC_WIDTH-1:0] x);
    logic signed [ACC_WIDTH-1:0] hi;
    logic signed [ACC_WIDTH-1:0] lo;
    hi = {{(ACC_WIDTH-QUAT_WIDTH+1){1'b0}}, {(QUAT_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      return {1'b0, {(QUAT_WIDTH-1){1'b1}}};
    end else if (x < lo) begin
      return {1'b1, {(QUAT_WIDTH-1){1'b0}}};
    end
    return x[QUAT_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/qrc_useq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion rotate/compose microsequencer
// Step counter over the microprogram table, with dispatch on the operation
// and a final step that waits for a free result register.
// ----------------------------------------------------------------------------
module qrc_useq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qrc_pkg::seq_cmd_t   cmd_i,
  output qrc_pkg::ctrl_t      ctrl_o,
  output qrc_pkg::seq_status_t st_o
);

  logic                      busy_q, busy_d;
  logic [qrc_pkg::PC_W-1:0]  pc_q, pc_d;
  qrc_pkg::ctrl_t            word;

  always_comb begin
    word    = qrc_pkg::ucode(pc_q);
    ctrl_o  = busy_q ? word : qrc_pkg::CTRL_IDLE;
    st_o.busy = busy_q;
    st_o.done = busy_q && (word.seq == qrc_pkg::SEQ_END) && cmd_i.out_free;
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      pc_d   = qrc_pkg::PC_W'(qrc_pkg::DISPATCH_ADDR);
    end else if (busy_q) begin
      case (word.seq)
        qrc_pkg::SEQ_NEXT:     pc_d = pc_q + qrc_pkg::PC_W'(1);
        qrc_pkg::SEQ_DISPATCH: pc_d = qrc_pkg::entry(cmd_i.op);
        qrc_pkg::SEQ_END: begin
          if (cmd_i.out_free) begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= qrc_pkg::PC_W'(qrc_pkg::DISPATCH_ADDR);
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("sequencer started while busy");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_o.done |=> !busy_q)
    else $error("sequencer still busy after finishing");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= qrc_pkg::PC_W'(qrc_pkg::LAST_ADDR)))
    else $error("step counter left the microprogram");

  a_rise_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> (pc_q == qrc_pkg::PC_W'(qrc_pkg::DISPATCH_ADDR)))
    else $error("program did not begin at dispatch");

endmodule
`default_nettype wire

// ===== src/qrc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion rotate/compose datapath
// One signed multiplier with a product register, an accumulator, and the
// cross product, rotated vector, new quaternion and held quaternion registers.
// ----------------------------------------------------------------------------
module qrc_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qrc_pkg::ctrl_t ctrl_i,
  input  qrc_pkg::req_t  req_i,
  output qrc_pkg::rsp_t  rsp_o
);

  localparam int QW = qrc_pkg::QUAT_WIDTH;
  localparam int CW = qrc_pkg::CROSS_WIDTH;
  localparam int PW = qrc_pkg::PROD_WIDTH;
  localparam int AW = qrc_pkg::ACC_WIDTH;
  localparam int RW = qrc_pkg::ROT_WIDTH;
  localparam int QF = qrc_pkg::QUAT_FRAC;

  logic signed [QW-1:0] u_q [4];
  logic signed [QW-1:0] n_q [4];
  logic signed [CW-1:0] c_q [3];
  logic signed [RW-1:0] r_q [3];
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [AW-1:0] acc_q, acc_d;

  logic signed [QW-1:0] mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [AW-1:0] prod_ext;
  logic signed [AW-1:0] acc_sh_q;   // floor shift by the fraction width
  logic signed [AW-1:0] acc_sh_t;   // floor shift that also doubles
  logic signed [RW-1:0] v_sel;

  always_comb begin
    case (ctrl_i.mul_a)
      qrc_pkg::SA_X: mul_a = u_q[0];
      qrc_pkg::SA_Y: mul_a = u_q[1];
      qrc_pkg::SA_Z: mul_a = u_q[2];
      qrc_pkg::SA_W: mul_a = u_q[3];
      default:       mul_a = u_q[3];
    endcase
    case (ctrl_i.mul_b)
      qrc_pkg::SB_V0: mul_b = CW'($signed(req_i.vec_x));
      qrc_pkg::SB_V1: mul_b = CW'($signed(req_i.vec_y));
      qrc_pkg::SB_V2: mul_b = CW'($signed(req_i.vec_z));
      qrc_pkg::SB_C0: mul_b = c_q[0];
      qrc_pkg::SB_C1: mul_b = c_q[1];
      qrc_pkg::SB_C2: mul_b = c_q[2];
      qrc_pkg::SB_Q0: mul_b = CW'($signed(req_i.quat_x));
      qrc_pkg::SB_Q1: mul_b = CW'($signed(req_i.quat_y));
      qrc_pkg::SB_Q2: mul_b = CW'($signed(req_i.quat_z));
      qrc_pkg::SB_Q3: mul_b = CW'($signed(req_i.quat_w));
      default:        mul_b = '0;
    endcase
    case (ctrl_i.wb_idx)
      2'd0:    v_sel = RW'($signed(req_i.vec_x));
      2'd1:    v_sel = RW'($signed(req_i.vec_y));
      default: v_sel = RW'($signed(req_i.vec_z));
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = AW'(prod_q);
  assign acc_sh_q = acc_q >>> QF;
  assign acc_sh_t = acc_q >>> (QF - 1);

  always_comb begin
    case (ctrl_i.acc)
      qrc_pkg::ACC_LOAD: acc_d = prod_ext;
      qrc_pkg::ACC_ADD:  acc_d = acc_q + prod_ext;
      qrc_pkg::ACC_SUB:  acc_d = acc_q - prod_ext;
      default:           acc_d = acc_q;
    endcase
  end

  // Working registers; their contents are defined by the program before use.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    case (ctrl_i.wb)
      qrc_pkg::WB_CROSS: begin
        if (ctrl_i.wb_idx != 2'd3) begin
          c_q[ctrl_i.wb_idx] <= $signed(acc_sh_q[CW-1:0]);
        end
      end
      qrc_pkg::WB_RINIT: begin
        if (ctrl_i.wb_idx != 2'd3) begin
          r_q[ctrl_i.wb_idx] <= v_sel + $signed(acc_sh_t[RW-1:0]);
        end
      end
      qrc_pkg::WB_RADD: begin
        if (ctrl_i.wb_idx != 2'd3) begin
          r_q[ctrl_i.wb_idx] <= r_q[ctrl_i.wb_idx] + $signed(acc_sh_t[RW-1:0]);
        end
      end
      qrc_pkg::WB_NEW: n_q[ctrl_i.wb_idx] <= qrc_pkg::sat_quat(acc_sh_q);
      default: ;
    endcase
  end

  // Held orientation, identity after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q[0] <= '0;
      u_q[1] <= '0;
      u_q[2] <= '0;
      u_q[3] <= qrc_pkg::QUAT_ONE;
    end else if (ctrl_i.wb == qrc_pkg::WB_COMMIT_N) begin
      u_q <= n_q;
    end else if (ctrl_i.wb == qrc_pkg::WB_COMMIT_Q) begin
      u_q[0] <= req_i.quat_x;
      u_q[1] <= req_i.quat_y;
      u_q[2] <= req_i.quat_z;
      u_q[3] <= req_i.quat_w;
    end
  end

  always_comb begin
    rsp_o.rot_x = qrc_pkg::sat_vec(r_q[0]);
    rsp_o.rot_y = qrc_pkg::sat_vec(r_q[1]);
    rsp_o.rot_z = qrc_pkg::sat_vec(r_q[2]);
    rsp_o.cur_x = u_q[0];
    rsp_o.cur_y = u_q[1];
    rsp_o.cur_z = u_q[2];
    rsp_o.cur_w = u_q[3];
  end

endmodule
`default_nettype wire

// ===== src/quaternion_rotate_compose_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion rotate/compose unit
// Holds one orientation quaternion and rotates vectors by it, composes it
// with incoming quaternions or loads it, one request at a time.
// ----------------------------------------------------------------------------
// The unit holds an orientation quaternion in Q2.14, identity after reset.
// Each request carries an op: rotate (0) turns the Q12.12 vector by the held
// quaternion as v + 2w(u x v) + 2u x (u x v); compose (1) replaces the held
// quaternion by the Hamilton product held * request; load (2) takes the
// request's quaternion; the unused code changes nothing. Every request gives
// exactly one result holding the quaternion as it stands afterwards, and the
// rotated vector for a rotate (zero otherwise). Products are floor shifted and
// results saturate. All arithmetic runs on a single signed multiplier with one
// product per cycle, stepped by a microprogram, so that multiplier sets the
// rate, and a new request is taken only after the result of the previous one
// is written. A finished result sits in an output register, so the next
// request is accepted while the previous result still waits; the unit only
// stalls when a finished result finds the output register still full.
module quaternion_rotate_compose_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qrc_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qrc_pkg::rsp_t  out_rsp_o
);

  qrc_pkg::req_t        req_q;
  qrc_pkg::rsp_t        rsp_q, rsp_d;
  qrc_pkg::rsp_t        dp_rsp;
  logic                 out_valid_q;
  logic                 in_accept;
  qrc_pkg::seq_cmd_t    seq_cmd;
  qrc_pkg::seq_status_t seq_st;
  qrc_pkg::ctrl_t       ctrl;

  // A request is taken whenever no program is running.
  assign in_ready_o = !seq_st.busy;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    seq_cmd.start    = in_accept;
    seq_cmd.out_free = !out_valid_q || out_ready_i;
    seq_cmd.op       = req_q.op;
  end

  // The request register feeds the datapath for the whole program.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
  end

  qrc_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (seq_cmd),
    .ctrl_o (ctrl),
    .st_o   (seq_st)
  );

  qrc_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_q),
    .rsp_o  (dp_rsp)
  );

  // Only a rotate reports a vector; every other op reports zero there.
  always_comb begin
    rsp_d = dp_rsp;
    if (req_q.op != qrc_pkg::OP_ROTATE) begin
      rsp_d.rot_x = '0;
      rsp_d.rot_y = '0;
      rsp_d.rot_z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_st.done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_st.done) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_st.done |-> (!out_valid_q || out_ready_i))
    else $error("finished result would overwrite a waiting one");

  a_rot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_st.done && (req_q.op != qrc_pkg::OP_ROTATE)) |=>
      (out_rsp_o.rot_x == '0) && (out_rsp_o.rot_y == '0) && (out_rsp_o.rot_z == '0))
    else $error("non-rotate result carries a vector");

endmodule
`default_nettype wire

// ===== test/qrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion rotate/compose checker
// Watches both channels of the unit and keeps its own copy of the held
// orientation. For every accepted request it predicts the result, and it
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module qrc_checker
  import qrc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  req_t in_req_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  rsp_t out_rsp_i,
  output int   mismatch_o,
  output int   pending_o,
  output int   results_o,
  output int   rotates_o,
  output int   composes_o,
  output int   loads_o,
  output int   unused_o,
  output int   clamps_o
);

  // Orientation as the unit should hold it.
  logic signed [QUAT_WIDTH-1:0] held_x;
  logic signed [QUAT_WIDTH-1:0] held_y;
  logic signed [QUAT_WIDTH-1:0] held_z;
  logic signed [QUAT_WIDTH-1:0] held_w;

  // Predicted poses (rotated vector plus orientation), oldest first.
  rsp_t pose_due_q[$];

  function automatic longint clamp_to(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clamps_o++;
      return hi;
    end else if (v < lo) begin
      clamps_o++;
      return lo;
    end
    return v;
  endfunction

  // Applies one request to the held orientation and returns the pose the
  // unit must report for it. All products are exact in 64 bits and >>> on a
  // signed longint is the floor shift.
  task automatic step_pose(input req_t r, output rsp_t p);
    longint ux, uy, uz, uw;
    longint vx, vy, vz;
    longint qx, qy, qz, qw;
    longint c0, c1, c2, d0, d1, d2;
    longint nx, ny, nz, nw;
    ux = longint'(held_x);
    uy = longint'(held_y);
    uz = longint'(held_z);
    uw = longint'(held_w);
    vx = longint'($signed(r.vec_x));
    vy = longint'($signed(r.vec_y));
    vz = longint'($signed(r.vec_z));
    qx = longint'($signed(r.quat_x));
    qy = longint'($signed(r.quat_y));
    qz = longint'($signed(r.quat_z));
    qw = longint'($signed(r.quat_w));
    p = '0;
    case (r.op)
      OP_ROTATE: begin
        c0 = (uy * vz - uz * vy) >>> QUAT_FRAC;
        c1 = (uz * vx - ux * vz) >>> QUAT_FRAC;
        c2 = (ux * vy - uy * vx) >>> QUAT_FRAC;
        d0 = (uy * c2 - uz * c1) >>> (QUAT_FRAC - 1);
        d1 = (uz * c0 - ux * c2) >>> (QUAT_FRAC - 1);
        d2 = (ux * c1 - uy * c0) >>> (QUAT_FRAC - 1);
        p.rot_x = VEC_WIDTH'(clamp_to(vx + ((uw * c0) >>> (QUAT_FRAC - 1)) + d0, VEC_WIDTH));
        p.rot_y = VEC_WIDTH'(clamp_to(vy + ((uw * c1) >>> (QUAT_FRAC - 1)) + d1, VEC_WIDTH));
        p.rot_z = VEC_WIDTH'(clamp_to(vz + ((uw * c2) >>> (QUAT_FRAC - 1)) + d2, VEC_WIDTH));
        rotates_o++;
      end
      OP_COMPOSE: begin
        // Held quaternion on the left of the Hamilton product.
        nx = uw * qx + ux * qw + uy * qz - uz * qy;
        ny = uw * qy - ux * qz + uy * qw + uz * qx;
        nz = uw * qz + ux * qy - uy * qx + uz * qw;
        nw = uw * qw - ux * qx - uy * qy - uz * qz;
        held_x = QUAT_WIDTH'(clamp_to(nx >>> QUAT_FRAC, QUAT_WIDTH));
        held_y = QUAT_WIDTH'(clamp_to(ny >>> QUAT_FRAC, QUAT_WIDTH));
        held_z = QUAT_WIDTH'(clamp_to(nz >>> QUAT_FRAC, QUAT_WIDTH));
        held_w = QUAT_WIDTH'(clamp_to(nw >>> QUAT_FRAC, QUAT_WIDTH));
        composes_o++;
      end
      OP_LOAD: begin
        held_x = r.quat_x;
        held_y = r.quat_y;
        held_z = r.quat_z;
        held_w = r.quat_w;
        loads_o++;
      end
      default: begin
        unused_o++;
      end
    endcase
    p.cur_x = held_x;
    p.cur_y = held_y;
    p.cur_z = held_z;
    p.cur_w = held_w;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatch_o++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t pred;
    if (!rst_ni) begin
      held_x = '0;
      held_y = '0;
      held_z = '0;
      held_w = QUAT_ONE;
      pose_due_q.delete();
      pending_o = 0;
    end else begin
      // A result can never belong to a request taken at the same edge, so the
      // output side is handled first.
      if (out_valid_i && out_ready_i) begin
        if (pose_due_q.size() == 0) begin
          mismatch_o++;
          $error("result arrived with no request outstanding");
        end else begin
          want = pose_due_q.pop_front();
          check_field("rot_x", want.rot_x, out_rsp_i.rot_x);
          check_field("rot_y", want.rot_y, out_rsp_i.rot_y);
          check_field("rot_z", want.rot_z, out_rsp_i.rot_z);
          check_field("cur_x", want.cur_x, out_rsp_i.cur_x);
          check_field("cur_y", want.cur_y, out_rsp_i.cur_y);
          check_field("cur_z", want.cur_z, out_rsp_i.cur_z);
          check_field("cur_w", want.cur_w, out_rsp_i.cur_w);
          results_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_pose(in_req_i, pred);
        pose_due_q.push_back(pred);
      end
      pending_o = pose_due_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion rotate/compose unit testbench
// Drives rotate, compose, load and unused-op requests into the unit with
// randomized gaps and back-pressure, and lets the checker predict and compare
// every result. Ends with a summary and a pass or fail verdict.
// ----------------------------------------------------------------------------
module tb;
  import qrc_pkg::*;

  // The package names the three real ops; the fourth code must be a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1050;
  localparam int PHASES       = 4;
  // Long output hold used to fill the unit and stall its input.
  localparam int LONG_HOLD    = 400;
  // Cycles without any handshake before the run is declared hung. The
  // slowest legal stretch is the long hold plus one compose.
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 30;

  localparam logic signed [VEC_WIDTH-1:0]  VEC_MAX  =
    VEC_WIDTH'((64'sd1 <<< (VEC_WIDTH - 1)) - 1);
  localparam logic signed [VEC_WIDTH-1:0]  VEC_MIN  = ~VEC_MAX;
  localparam logic signed [QUAT_WIDTH-1:0] QUAT_MAX =
    QUAT_WIDTH'((64'sd1 <<< (QUAT_WIDTH - 1)) - 1);
  localparam logic signed [QUAT_WIDTH-1:0] QUAT_MIN = ~QUAT_MAX;
  // cos(45 deg) in Q2.14: a quarter turn about one axis uses it twice.
  localparam logic signed [QUAT_WIDTH-1:0] COS_45   = 16'sd11585;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  req_t in_req_i    = '0;
  logic in_ready_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Number of long output holds asked for so far.
  int hold_count     = 0;

  int mismatches, due_count, results, rotates, composes, loads, unused, clamps;

  quaternion_rotate_compose_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  qrc_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_i   (out_rsp_o),
    .mismatch_o  (mismatches),
    .pending_o   (due_count),
    .results_o   (results),
    .rotates_o   (rotates),
    .composes_o  (composes),
    .loads_o     (loads),
    .unused_o    (unused),
    .clamps_o    (clamps)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Field generators. Vectors mix the full range, small magnitudes that keep
  // rotations away from saturation, and the corner values.
  function automatic logic signed [VEC_WIDTH-1:0] pick_vec();
    logic signed [VEC_WIDTH-1:0] v;
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(3))
          0:       v = VEC_MAX;
          1:       v = VEC_MIN;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2:    v = VEC_WIDTH'(int'($urandom_range(131072)) - 65536);
      default: v = VEC_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  // Near-unit parts stay within one in Q2.14, so composed orientations keep
  // a sensible size; the rest reach the full range and the corners.
  function automatic logic signed [QUAT_WIDTH-1:0] pick_quat(input bit near_unit);
    logic signed [QUAT_WIDTH-1:0] q;
    if (near_unit) begin
      q = QUAT_WIDTH'(int'($urandom_range(32768)) - 16384);
    end else begin
      case ($urandom_range(4))
        0:       q = QUAT_MAX;
        1:       q = QUAT_MIN;
        2:       q = QUAT_ONE;
        default: q = QUAT_WIDTH'($urandom);
      endcase
    end
    return q;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   pick;
    bit   near_unit;
    pick      = $urandom_range(99);
    near_unit = ($urandom_range(99) < 65);
    r.vec_x   = pick_vec();
    r.vec_y   = pick_vec();
    r.vec_z   = pick_vec();
    r.quat_x  = pick_quat(near_unit);
    r.quat_y  = pick_quat(near_unit);
    r.quat_z  = pick_quat(near_unit);
    r.quat_w  = pick_quat(near_unit);
    if (pick < 40) begin
      r.op = OP_ROTATE;
    end else if (pick < 65) begin
      r.op = OP_COMPOSE;
    end else if (pick < 88) begin
      r.op = OP_LOAD;
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  // Rotate request; the quaternion fields are junk the unit must ignore.
  function automatic req_t rot_req(input logic signed [VEC_WIDTH-1:0] x,
                                   input logic signed [VEC_WIDTH-1:0] y,
                                   input logic signed [VEC_WIDTH-1:0] z);
    req_t r;
    r       = random_req();
    r.op    = OP_ROTATE;
    r.vec_x = x;
    r.vec_y = y;
    r.vec_z = z;
    return r;
  endfunction

  // Compose or load request; the vector fields are junk the unit must ignore.
  function automatic req_t quat_req(input logic [1:0] op,
                                    input logic signed [QUAT_WIDTH-1:0] x,
                                    input logic signed [QUAT_WIDTH-1:0] y,
                                    input logic signed [QUAT_WIDTH-1:0] z,
                                    input logic signed [QUAT_WIDTH-1:0] w);
    req_t r;
    r        = random_req();
    r.op     = op;
    r.quat_x = x;
    r.quat_y = y;
    r.quat_z = z;
    r.quat_w = w;
    return r;
  endfunction

  function automatic req_t unused_req();
    req_t r;
    r    = random_req();
    r.op = OP_UNUSED;
    return r;
  endfunction

  // Offers one request and waits for the edge that accepts it. Valid stays
  // high into the next request unless a random sender gap follows, and the
  // gap drops valid once per idle cycle.
  task automatic send_req(input req_t r);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Result side. Back-pressure is random per cycle; on request it holds
  // ready low for a long stretch, counted here, so the output register fills
  // and the unit has to stop taking requests.
  initial begin
    int hold_left;
    int holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    forever begin
      @(posedge clk_i);
      if (hold_count != holds_taken) begin
        holds_taken = hold_count;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any stretch without a handshake on either side beyond the
  // limit means the unit has hung.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int p;
    int i;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests, no idling on either side. First the identity
    // orientation must hand vectors back untouched, corners included.
    send_req(rot_req(VEC_MAX, VEC_MIN, '0));
    send_req(rot_req('1, 24'sd1, VEC_MIN));
    send_req(unused_req());
    // Quarter turn about z: x maps onto y.
    send_req(quat_req(OP_LOAD, '0, '0, COS_45, COS_45));
    send_req(rot_req(24'sd4096, '0, '0));
    send_req(rot_req(VEC_MAX, VEC_MAX, VEC_MAX));
    send_req(quat_req(OP_COMPOSE, '0, '0, COS_45, COS_45));
    send_req(rot_req(VEC_MIN, VEC_MAX, 24'sd12345));
    // Out-of-range orientations drive both rotation and compose into
    // saturation.
    send_req(quat_req(OP_LOAD, QUAT_MAX, QUAT_MIN, QUAT_MAX, QUAT_MIN));
    send_req(rot_req(VEC_MAX, VEC_MIN, VEC_MAX));
    send_req(rot_req(VEC_MIN, VEC_MIN, VEC_MIN));
    send_req(quat_req(OP_COMPOSE, QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX));
    send_req(quat_req(OP_COMPOSE, QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN));
    send_req(unused_req());
    send_req(quat_req(OP_LOAD, '0, '0, '0, '0));
    send_req(rot_req(pick_vec(), pick_vec(), pick_vec()));
    send_req(quat_req(OP_COMPOSE, pick_quat(1'b0), pick_quat(1'b0),
                      pick_quat(1'b0), pick_quat(1'b0)));
    send_req(quat_req(OP_LOAD, QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN));
    send_req(quat_req(OP_COMPOSE, QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN));
    send_req(rot_req(VEC_MAX, VEC_MAX, VEC_MAX));
    // Small negative values check that every shift rounds toward minus
    // infinity.
    send_req(quat_req(OP_LOAD, '0, '0, '0, QUAT_ONE));
    send_req(quat_req(OP_COMPOSE, '1, '1, '1, '1));
    send_req(rot_req('1, '1, '1));
    send_req(unused_req());

    // Random requests in four idling phases: none, sender gaps, receiver
    // stalls, both. The long output hold lands in the first and the third.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 25;
          recv_stall_pct = 25;
        end
      endcase
      if (p == 0 || p == 2) begin
        hold_count++;
      end
      for (i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        send_req(random_req());
      end
    end
    in_valid_i <= 1'b0;

    // Let every outstanding result come back, then a few more cycles to
    // catch anything extra the unit might emit.
    while (due_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d rotates, %0d composes, %0d loads, %0d unused-op.",
             results, rotates, composes, loads, unused);
    $display("%0d fields saturated; idling: none, sender, receiver, both, %0d-cycle hold.",
             clamps, LONG_HOLD);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
